### rtl/joint_angle_assist_mapper_macros.svh
// assertion macros shared by the joint angle assist mapper rtl
`ifndef JOINT_ANGLE_ASSIST_MAPPER_MACROS_SVH
`define JOINT_ANGLE_ASSIST_MAPPER_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define JAAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition must never be seen outside reset
`define JAAM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define JAAM_ASSERT(lbl, prop, msg)
`define JAAM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/jaam_pkg.sv
// shared constants, types and the cordic arctangent table of the joint angle mapper
package jaam_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TableLen     = 24;
  localparam int StepW        = $clog2(TableLen);
  localparam int XyW          = 32;
  localparam int ZW           = 32;
  localparam int RoundShift   = 17;

  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [15:0] PiQ13     = 16'sd25736;
  localparam logic        [7:0]  IntentRaise = 8'd7;
  localparam logic        [7:0]  IntentLower = 8'd8;

  typedef enum logic [2:0] {
    RegShoulderLink = 3'd0,
    RegElbowLink    = 3'd1,
    RegAssistUp     = 3'd2,
    RegAssistDown   = 3'd3,
    RegAssistStep   = 3'd4,
    RegTimeoutMs    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic        [14:0] shoulder_link;
    logic        [14:0] elbow_link;
    logic signed [15:0] assist_up;
    logic signed [15:0] assist_down;
    logic        [14:0] assist_step;
    logic        [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [16:0] diff;
    logic        [14:0] link;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] angle;
  } cordic_rsp_t;

  // atan(2^-i) in q2.30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [StepW-1:0] idx);
    logic signed [ZW-1:0] val;
    case (idx)
      5'd0:    val = 32'sd843314857;
      5'd1:    val = 32'sd497837829;
      5'd2:    val = 32'sd263043837;
      5'd3:    val = 32'sd133525159;
      5'd4:    val = 32'sd67021687;
      5'd5:    val = 32'sd33543516;
      5'd6:    val = 32'sd16775851;
      5'd7:    val = 32'sd8388437;
      5'd8:    val = 32'sd4194283;
      5'd9:    val = 32'sd2097149;
      5'd10:   val = 32'sd1048576;
      5'd11:   val = 32'sd524288;
      5'd12:   val = 32'sd262144;
      5'd13:   val = 32'sd131072;
      5'd14:   val = 32'sd65536;
      5'd15:   val = 32'sd32768;
      5'd16:   val = 32'sd16384;
      5'd17:   val = 32'sd8192;
      5'd18:   val = 32'sd4096;
      5'd19:   val = 32'sd2048;
      5'd20:   val = 32'sd1024;
      5'd21:   val = 32'sd512;
      5'd22:   val = 32'sd256;
      5'd23:   val = 32'sd128;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### rtl/jaam_cfg.sv
// configuration register file of the joint angle mapper
module jaam_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output jaam_pkg::cfg_t      cfg_o
);

  jaam_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shoulder_link <= 15'd1229;
      cfg_q.elbow_link    <= 15'd1024;
      cfg_q.assist_up     <= 16'sd9830;
      cfg_q.assist_down   <= 16'sd0;
      cfg_q.assist_step   <= 15'd3277;
      cfg_q.timeout_ms    <= 16'd1000;
    end else if (cfg_valid_i) begin
      unique case (jaam_pkg::reg_idx_e'(cfg_index_i))
        jaam_pkg::RegShoulderLink: cfg_q.shoulder_link <= cfg_data_i[14:0];
        jaam_pkg::RegElbowLink:    cfg_q.elbow_link    <= cfg_data_i[14:0];
        jaam_pkg::RegAssistUp:     cfg_q.assist_up     <= $signed(cfg_data_i);
        jaam_pkg::RegAssistDown:   cfg_q.assist_down   <= $signed(cfg_data_i);
        jaam_pkg::RegAssistStep:   cfg_q.assist_step   <= cfg_data_i[14:0];
        jaam_pkg::RegTimeoutMs:    cfg_q.timeout_ms    <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

### rtl/jaam_cordic.sv
// iterative vectoring cordic giving atan2(diff, link) in q3.13
`include "joint_angle_assist_mapper_macros.svh"

module jaam_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  jaam_pkg::cordic_req_t req_i,
  output jaam_pkg::cordic_rsp_t rsp_o
);

  localparam logic [jaam_pkg::StepW-1:0] LastStep =
    jaam_pkg::StepW'(jaam_pkg::CORDIC_STEPS - 1);

  typedef enum logic [1:0] {C_IDLE, C_ITER, C_ROUND} state_e;

  state_e                             state_q;
  logic   [jaam_pkg::StepW-1:0]       step_q;
  logic                               done_q;
  logic signed [15:0]                 angle_q;
  logic signed [jaam_pkg::XyW-1:0]    x_q, y_q, x_d, y_d, xs, ys, x_ld, y_ld;
  logic signed [jaam_pkg::ZW-1:0]     z_q, z_d, atan_v;
  logic signed [jaam_pkg::ZW:0]       round_sum;
  logic signed [15:0]                 edge_angle;

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = angle_q;

  // scaled by 4096 on load
  assign x_ld = $signed({5'b0, req_i.link, 12'b0});
  assign y_ld = $signed({{3{req_i.diff[16]}}, req_i.diff, 12'b0});

  // one micro-rotation, shifts floor toward minus infinity
  always_comb begin
    xs     = x_q >>> step_q;
    ys     = y_q >>> step_q;
    atan_v = jaam_pkg::atan_q30(step_q);
    if (!y_q[jaam_pkg::XyW-1]) begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + atan_v;
    end else begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - atan_v;
    end
  end

  assign round_sum = $signed({z_q[jaam_pkg::ZW-1], z_q}) + 33'sd65536;

  // zero link length: straight up or down by the sign of diff, zero for a zero diff
  always_comb begin
    if (req_i.diff > 17'sd0) begin
      edge_angle = jaam_pkg::HalfPiQ13;
    end else if (req_i.diff < 17'sd0) begin
      edge_angle = -jaam_pkg::HalfPiQ13;
    end else begin
      edge_angle = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
      angle_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (req_i.start) begin
            step_q <= '0;
            if (req_i.link == '0) begin
              done_q  <= 1'b1;
              angle_q <= edge_angle;
            end else begin
              state_q <= C_ITER;
            end
          end
        end
        C_ITER: begin
          step_q <= step_q + 1'b1;
          if (step_q == LastStep) begin
            state_q <= C_ROUND;
          end
        end
        C_ROUND: begin
          done_q  <= 1'b1;
          angle_q <= round_sum[jaam_pkg::ZW:jaam_pkg::RoundShift];
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && req_i.start) begin
      x_q <= x_ld;
      y_q <= y_ld;
      z_q <= '0;
    end else if (state_q == C_ITER) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  `JAAM_ASSERT(a_done_single, done_q |=> !done_q, "cordic done longer than one cycle")
  `JAAM_ASSERT_NEVER(a_start_busy, req_i.start && state_q != C_IDLE, "cordic started while busy")
  `JAAM_ASSERT(a_iter_end, (state_q == C_ITER && step_q == LastStep) |=> state_q == C_ROUND,
               "cordic missed its last step")

endmodule

### rtl/joint_angle_assist_mapper.sv
// joint angle assist mapper top level: sequencer, assist ramp, clamps and stream ports
// a sample word runs the single cordic unit once per joint (start, wait), then passes the
// assist and output states, where it may hold for the receiver; a zero link skips the iterations
// an intention word is only stored; a new word is taken once the sequencer is idle again
// reset (async, active low) restores the register defaults, clears intention and assist
module joint_angle_assist_mapper (
  input  logic          clk_i,
  input  logic          rst_ni,
  // sample and intention words
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // time_ms[31:0], intent_id[39:32], disp_a..disp_h 16 bits each from bit 40 up
  input  logic [167:0]  s_axis_tdata_i,
  // req_type[0]
  input  logic          s_axis_tuser_i,
  // joint command words
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // right_shoulder[14:0], left_shoulder[29:15], right_elbow[44:30], left_elbow[59:45], zero
  output logic [63:0]   m_axis_tdata_o,
  // register writes
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  `include "joint_angle_assist_mapper_macros.svh"

  typedef enum logic [2:0] {S_IDLE, S_START, S_WAIT, S_ASSIST, S_OUT} state_e;

  typedef struct packed {
    logic        [14:0] le;
    logic        [14:0] re;
    logic signed [14:0] ls;
    logic signed [14:0] rs;
  } out_t;

  localparam logic signed [16:0] ShMax = 17'(jaam_pkg::HalfPiQ13);
  localparam logic signed [16:0] ShMin = -ShMax;

  jaam_pkg::cfg_t         cfg;
  jaam_pkg::cordic_req_t  cordic_req;
  jaam_pkg::cordic_rsp_t  cordic_rsp;

  state_e              state_q;
  logic [1:0]          joint_q;
  logic [7:0]          last_intent_q;
  logic [31:0]         intent_time_q;
  logic signed [15:0]  assist_q;
  out_t                out_q, out_d;
  logic                out_valid_q;

  // captured sample and per-joint results
  logic [31:0]         time_q;
  logic signed [15:0]  disp_q [8];
  logic signed [15:0]  angle_q [4];
  logic signed [15:0]  add_q;

  logic                s_acc, m_acc;
  logic signed [16:0]  diff;

  // assist ramp
  logic [31:0]         age;
  logic                fresh, raise, lower, active;
  logic signed [15:0]  target, assist_next, add_d;
  logic signed [17:0]  up_sum, dn_sum;

  // clamp stage
  logic signed [16:0]  rs_sum, ls_sum, rs_cl, ls_cl;
  logic signed [15:0]  re_cl, le_cl;

  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc           = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_q};

  jaam_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // joint order: right shoulder, left shoulder, right elbow, left elbow
  always_comb begin
    case (joint_q)
      2'd0:    diff = $signed({disp_q[1][15], disp_q[1]}) - $signed({disp_q[0][15], disp_q[0]});
      2'd1:    diff = $signed({disp_q[3][15], disp_q[3]}) - $signed({disp_q[2][15], disp_q[2]});
      2'd2:    diff = $signed({disp_q[5][15], disp_q[5]}) - $signed({disp_q[4][15], disp_q[4]});
      default: diff = $signed({disp_q[7][15], disp_q[7]}) - $signed({disp_q[6][15], disp_q[6]});
    endcase
  end

  assign cordic_req.start = (state_q == S_START);
  assign cordic_req.diff  = diff;
  assign cordic_req.link  = joint_q[1] ? cfg.elbow_link : cfg.shoulder_link;

  jaam_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cordic_req),
    .rsp_o  (cordic_rsp)
  );

  // intention age wraps with the millisecond counter
  always_comb begin
    age    = time_q - intent_time_q;
    fresh  = (age <= {16'b0, cfg.timeout_ms});
    raise  = (last_intent_q == jaam_pkg::IntentRaise);
    lower  = (last_intent_q == jaam_pkg::IntentLower);
    active = fresh && (raise || lower);
    target = raise ? cfg.assist_up : cfg.assist_down;
    up_sum = $signed({{2{assist_q[15]}}, assist_q}) + $signed({3'b0, cfg.assist_step});
    dn_sum = $signed({{2{assist_q[15]}}, assist_q}) - $signed({3'b0, cfg.assist_step});
    // step toward the target without running past it
    if (assist_q < target) begin
      assist_next = (up_sum > 18'(target)) ? target : up_sum[15:0];
    end else if (assist_q > target) begin
      assist_next = (dn_sum < 18'(target)) ? target : dn_sum[15:0];
    end else begin
      assist_next = assist_q;
    end
    add_d = active ? assist_next : '0;
  end

  // assist goes on both shoulders at full width, then every joint is clamped
  always_comb begin
    rs_sum = $signed({angle_q[0][15], angle_q[0]}) + $signed({add_q[15], add_q});
    ls_sum = $signed({angle_q[1][15], angle_q[1]}) + $signed({add_q[15], add_q});
    rs_cl  = (rs_sum < ShMin) ? ShMin : ((rs_sum > ShMax) ? ShMax : rs_sum);
    ls_cl  = (ls_sum < ShMin) ? ShMin : ((ls_sum > ShMax) ? ShMax : ls_sum);
    if (angle_q[2] < 16'sd0) begin
      re_cl = '0;
    end else if (angle_q[2] > jaam_pkg::PiQ13) begin
      re_cl = jaam_pkg::PiQ13;
    end else begin
      re_cl = angle_q[2];
    end
    if (angle_q[3] < 16'sd0) begin
      le_cl = '0;
    end else if (angle_q[3] > jaam_pkg::PiQ13) begin
      le_cl = jaam_pkg::PiQ13;
    end else begin
      le_cl = angle_q[3];
    end
    out_d.rs = rs_cl[14:0];
    out_d.ls = ls_cl[14:0];
    out_d.re = re_cl[14:0];
    out_d.le = le_cl[14:0];
  end

  // sequencer, intention state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      joint_q       <= '0;
      last_intent_q <= '0;
      intent_time_q <= '0;
      assist_q      <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (m_acc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            if (s_axis_tuser_i) begin
              joint_q <= '0;
              state_q <= S_START;
            end else begin
              // intention word: remember code and time stamp, nothing comes out
              last_intent_q <= s_axis_tdata_i[39:32];
              intent_time_q <= s_axis_tdata_i[31:0];
            end
          end
        end
        S_START: state_q <= S_WAIT;
        S_WAIT: begin
          if (cordic_rsp.done) begin
            joint_q <= joint_q + 2'd1;
            state_q <= (joint_q == 2'd3) ? S_ASSIST : S_START;
          end
        end
        S_ASSIST: begin
          if (active) begin
            assist_q <= assist_next;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold here while the previous result still waits downstream
          if (!out_valid_q || m_axis_tready_i) begin
            out_q       <= out_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // sample capture and per-joint results
  always_ff @(posedge clk_i) begin
    if (s_acc && s_axis_tuser_i) begin
      time_q <= s_axis_tdata_i[31:0];
      for (int k = 0; k < 8; k++) begin
        disp_q[k] <= s_axis_tdata_i[40 + 16*k +: 16];
      end
    end
    if (state_q == S_WAIT && cordic_rsp.done) begin
      angle_q[joint_q] <= cordic_rsp.angle;
    end
    if (state_q == S_ASSIST) begin
      add_q <= add_d;
    end
  end

  `JAAM_ASSERT_NEVER(a_done_outside_wait, cordic_rsp.done && state_q != S_WAIT,
                     "cordic result arrived while the sequencer was not waiting")
  `JAAM_ASSERT(a_sample_starts, (s_acc && s_axis_tuser_i) |=> state_q == S_START,
               "accepted sample did not start the joint sequence")
  `JAAM_ASSERT(a_shoulder_range,
               m_axis_tvalid_o |-> (out_q.rs >= ShMin && out_q.rs <= ShMax &&
                                    out_q.ls >= ShMin && out_q.ls <= ShMax),
               "shoulder command outside plus or minus half pi")
  `JAAM_ASSERT(a_elbow_range,
               m_axis_tvalid_o |-> (out_q.re <= 15'(jaam_pkg::PiQ13) &&
                                    out_q.le <= 15'(jaam_pkg::PiQ13)),
               "elbow command above pi")

endmodule

### tb/tb.sv
// self-checking bench for the joint angle assist mapper: directed and random words, scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // hold-off after the last result before a register write or the end of the run
  localparam int DrainCycles = 100;
  // limit on the whole run, with ample headroom over the slowest legal run
  localparam int CycleLimit = 600_000;
  localparam int PhaseWords = 92;
  localparam int NumPhases  = 8;
  // indexes the block must ignore
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  // one joint command word, right shoulder in the lowest bits
  typedef struct packed {
    logic        [14:0] left_elbow;
    logic        [14:0] right_elbow;
    logic signed [14:0] left_shoulder;
    logic signed [14:0] right_shoulder;
  } joint_cmd_t;

  // register copy, intention and assist state, and the joint commands still owed
  class joint_cmd_scoreboard;
    // atan(2^-i) in q2.30
    localparam longint AtanQ30 [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128
    };

    logic        [14:0] shoulder_link;
    logic        [14:0] elbow_link;
    logic signed [15:0] assist_up;
    logic signed [15:0] assist_down;
    logic        [14:0] assist_step;
    logic        [15:0] timeout_ms;
    logic        [7:0]  last_intent;
    logic        [31:0] intent_time;
    logic signed [15:0] assist_level;
    joint_cmd_t         expected_q[$];
    int unsigned        fails;

    function new();
      shoulder_link = 15'd1229;
      elbow_link    = 15'd1024;
      assist_up     = 16'sd9830;
      assist_down   = 16'sd0;
      assist_step   = 15'd3277;
      timeout_ms    = 16'd1000;
      last_intent   = '0;
      intent_time   = '0;
      assist_level  = '0;
      fails         = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        jaam_pkg::RegShoulderLink: shoulder_link = data[14:0];
        jaam_pkg::RegElbowLink:    elbow_link    = data[14:0];
        jaam_pkg::RegAssistUp:     assist_up     = data;
        jaam_pkg::RegAssistDown:   assist_down   = data;
        jaam_pkg::RegAssistStep:   assist_step   = data[14:0];
        jaam_pkg::RegTimeoutMs:    timeout_ms    = data;
        default: ;
      endcase
    endfunction

    // vectoring cordic, all shifts floor toward minus infinity
    function int atan2_q13(longint diff, int link);
      longint x, y, z, xs, ys;
      if (link == 0) begin
        if (diff > 0) return int'(jaam_pkg::HalfPiQ13);
        if (diff < 0) return -int'(jaam_pkg::HalfPiQ13);
        return 0;
      end
      x = longint'(link) * 4096;
      y = diff * 4096;
      z = 0;
      for (int i = 0; i < jaam_pkg::CORDIC_STEPS && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += AtanQ30[i];
        end else begin
          x -= ys;
          y += xs;
          z -= AtanQ30[i];
        end
      end
      return int'((z + 65536) >>> 17);
    endfunction

    function int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // an accepted input word: store an intention or queue the joint command it owes
    function void note_word(logic req, logic [167:0] word);
      logic [31:0] now;
      int          d[8];
      int          rs, ls, re, le, add, target, cur;
      joint_cmd_t  cmd;
      now = word[31:0];
      if (!req) begin
        last_intent = word[39:32];
        intent_time = now;
        return;
      end
      for (int k = 0; k < 8; k++) d[k] = int'($signed(word[40 + 16*k +: 16]));
      rs = atan2_q13(longint'(d[1] - d[0]), int'(shoulder_link));
      ls = atan2_q13(longint'(d[3] - d[2]), int'(shoulder_link));
      re = atan2_q13(longint'(d[5] - d[4]), int'(elbow_link));
      le = atan2_q13(longint'(d[7] - d[6]), int'(elbow_link));
      // assist ramps only while a raise or lower intention is fresh, age wraps at 32 bits
      add = 0;
      if ((now - intent_time) <= timeout_ms &&
          (last_intent == jaam_pkg::IntentRaise || last_intent == jaam_pkg::IntentLower)) begin
        target = (last_intent == jaam_pkg::IntentRaise) ? int'(assist_up) : int'(assist_down);
        cur = int'(assist_level);
        if (cur < target) begin
          cur += int'(assist_step);
          if (cur > target) cur = target;
        end else if (cur > target) begin
          cur -= int'(assist_step);
          if (cur < target) cur = target;
        end
        assist_level = cur[15:0];
        add = cur;
      end
      // shoulder sum at full width before the clamp
      rs = clamp_int(rs + add, -int'(jaam_pkg::HalfPiQ13), int'(jaam_pkg::HalfPiQ13));
      ls = clamp_int(ls + add, -int'(jaam_pkg::HalfPiQ13), int'(jaam_pkg::HalfPiQ13));
      re = clamp_int(re, 0, int'(jaam_pkg::PiQ13));
      le = clamp_int(le, 0, int'(jaam_pkg::PiQ13));
      cmd.right_shoulder = rs[14:0];
      cmd.left_shoulder  = ls[14:0];
      cmd.right_elbow    = re[14:0];
      cmd.left_elbow     = le[14:0];
      expected_q.push_back(cmd);
    endfunction

    function void check_word(logic [63:0] word);
      joint_cmd_t got, want;
      got = word[59:0];
      if (expected_q.size() == 0) begin
        $error("joint command word %h with none outstanding", word);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      if (got.right_shoulder !== want.right_shoulder) begin
        $error("right_shoulder: expected %0d, got %0d", want.right_shoulder, got.right_shoulder);
        fails++;
      end
      if (got.left_shoulder !== want.left_shoulder) begin
        $error("left_shoulder: expected %0d, got %0d", want.left_shoulder, got.left_shoulder);
        fails++;
      end
      if (got.right_elbow !== want.right_elbow) begin
        $error("right_elbow: expected %0d, got %0d", want.right_elbow, got.right_elbow);
        fails++;
      end
      if (got.left_elbow !== want.left_elbow) begin
        $error("left_elbow: expected %0d, got %0d", want.left_elbow, got.left_elbow);
        fails++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid_i;
  logic          s_axis_tready_o;
  logic [167:0]  s_axis_tdata_i;
  logic          s_axis_tuser_i;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i;
  logic [63:0]   m_axis_tdata_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [2:0]    cfg_index_i;
  logic [15:0]   cfg_data_i;

  joint_cmd_scoreboard sb;
  // per-phase switches that turn idling off on one side
  bit src_steady;
  bit sink_steady;

  joint_angle_assist_mapper u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // eight displacements: full range, around zero, or the extremes
  function automatic logic [127:0] pick_disps();
    logic [127:0] v;
    int           m;
    m = $urandom_range(0, 9);
    for (int k = 0; k < 8; k++) begin
      if (m < 4) begin
        v[16*k +: 16] = 16'($urandom());
      end else if (m < 9) begin
        v[16*k +: 16] = 16'($urandom_range(0, 8192) - 4096);
      end else begin
        case ($urandom_range(0, 2))
          0:       v[16*k +: 16] = 16'h8000;
          1:       v[16*k +: 16] = 16'h7FFF;
          default: v[16*k +: 16] = 16'h0000;
        endcase
      end
    end
    return v;
  endfunction

  // offer one word, after a random gap unless the source is steady, and hold it until it is taken
  task automatic send_word(input logic req, input logic [167:0] data);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= req;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_word(req, data);
  endtask

  task automatic send_sample(input logic [31:0] t, input logic [127:0] disps);
    send_word(1'b1, {disps, 8'($urandom()), t});
  endtask

  // displacement bits of an intention word are ignored, so they carry noise
  task automatic send_intent(input logic [31:0] t, input logic [7:0] id);
    send_word(1'b0, {pick_disps(), id, t});
  endtask

  // valid is left high so back-to-back writes never lower and raise it in one step
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(input logic [15:0] sh_link, input logic [15:0] el_link,
                                input logic [15:0] up, input logic [15:0] down,
                                input logic [15:0] stp, input logic [15:0] tmo);
    write_reg(jaam_pkg::RegShoulderLink, sh_link);
    write_reg(jaam_pkg::RegElbowLink, el_link);
    write_reg(jaam_pkg::RegAssistUp, up);
    write_reg(jaam_pkg::RegAssistDown, down);
    write_reg(jaam_pkg::RegAssistStep, stp);
    write_reg(jaam_pkg::RegTimeoutMs, tmo);
    // unused indexes must leave every register alone
    write_reg(RegSpareLo, 16'($urandom()));
    write_reg(RegSpareHi, 16'($urandom()));
    cfg_valid_i <= 1'b0;
  endtask

  // stop sending, wait for every owed word, then let a trailing intention settle
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one random word: mostly samples timed around the stored intention
  task automatic random_word();
    logic [31:0] t;
    logic [31:0] off;
    logic [7:0]  id;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      case ($urandom_range(0, 4))
        0, 1:    id = jaam_pkg::IntentRaise;
        2, 3:    id = jaam_pkg::IntentLower;
        default: id = 8'($urandom());
      endcase
      if ($urandom_range(0, 5) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      else t = $urandom();
      send_intent(t, id);
    end else begin
      case ($urandom_range(0, 9))
        0:       off = '0;
        1:       off = 32'(sb.timeout_ms);
        2:       off = 32'(sb.timeout_ms) + 1;
        3:       off = $urandom();
        default: off = $urandom_range(0, int'(sb.timeout_ms) + int'(sb.timeout_ms) / 8 + 1);
      endcase
      send_sample(sb.intent_time + off, pick_disps());
    end
  endtask

  // every taken joint command word is checked against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_word(m_axis_tdata_o);
  end

  // receiver: short bursts of ready with random stalls in between unless the sink is steady
  initial begin
    int gap;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      gap = sink_steady ? 0 : pick_gap();
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("run stopped after %0d cycles", cycle_count);
    $display("** joint_angle_assist_mapper: FAILED **");
    $finish;
  end

  initial begin
    sb = new();
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with the reset register values
    // zero displacements before any intention
    send_sample(32'd0, '0);
    // largest positive and negative differences, right elbow goes negative and clamps
    send_sample(32'd5, {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                        16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000});
    // differences equal to the link lengths, about plus and minus 45 degrees
    send_sample(32'd9, {16'd1024, 16'd0, 16'd1024, 16'd0,
                        16'd0, 16'd1229, 16'd1229, 16'd0});
    // raise ramps up to its target without overshoot, shoulder sum clamps
    send_intent(32'd100, jaam_pkg::IntentRaise);
    send_sample(32'd150, {16'd1024, 16'd0, 16'd1024, 16'd0, 16'd0, 16'd1229, 16'd1229, 16'd0});
    send_sample(32'd300, {16'd1024, 16'd0, 16'd1024, 16'd0, 16'd0, 16'd1229, 16'd1229, 16'd0});
    send_sample(32'd600, {16'd1024, 16'd0, 16'd1024, 16'd0, 16'd0, 16'd1229, 16'd1229, 16'd0});
    // age equal to the timeout still counts, one more does not
    send_sample(32'd1100, {16'd1024, 16'd0, 16'd1024, 16'd0, 16'd0, 16'd1229, 16'd1229, 16'd0});
    send_sample(32'd1101, {16'd1024, 16'd0, 16'd1024, 16'd0, 16'd0, 16'd1229, 16'd1229, 16'd0});
    // lower ramps back down to zero
    send_intent(32'd2000, jaam_pkg::IntentLower);
    send_sample(32'd2000, '0);
    send_sample(32'd2010, '0);
    send_sample(32'd2020, '0);
    send_sample(32'd2030, '0);
    // any other code adds nothing
    send_intent(32'd3000, 8'd9);
    send_sample(32'd3001, '0);
    // age across the 32-bit wrap: fresh, then stale
    send_intent(32'hFFFF_FF00, jaam_pkg::IntentRaise);
    send_sample(32'h0000_0100, '0);
    send_sample(32'h0000_0400, '0);

    // zero links, widest assist swing, largest step, zero timeout
    drain();
    apply_settings(16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0);
    send_intent(32'd500, jaam_pkg::IntentRaise);
    send_sample(32'd500, {16'd0, 16'd5, 16'd3, 16'd3, 16'd0, 16'd1, 16'd1, 16'd0});
    send_sample(32'd501, {16'd5, 16'd0, 16'd0, 16'd3, 16'd1, 16'd0, 16'd0, 16'd1});
    send_intent(32'd600, jaam_pkg::IntentLower);
    send_sample(32'd600, '0);
    send_sample(32'd600, '0);
    send_sample(32'd600, '0);

    // random phases, each behind a full drain so the sender also waits for the receiver
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0: apply_settings(16'd1229, 16'd1024, 16'd9830, 16'd0, 16'd3277, 16'd1000);
        // top bit of the 15-bit registers is dropped
        1: apply_settings(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
        2: apply_settings(16'd1, 16'd1, 16'h8000, 16'h7FFF, 16'd0, 16'd0);
        default: apply_settings(
            ($urandom_range(0, 7) == 0) ? 16'd0 :
              (($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 4096))),
            ($urandom_range(0, 7) == 0) ? 16'd0 :
              (($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 4096))),
            ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768) - 16384),
            ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768) - 16384),
            ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4000)),
            ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3000)));
      endcase
      // some phases run one side without any idling
      src_steady  = (p % 4 == 1);
      sink_steady = (p % 4 == 2);
      repeat (PhaseWords) random_word();
    end

    drain();
    if (sb.fails == 0) begin
      $display("** joint_angle_assist_mapper: PASSED **");
    end else begin
      $display("** joint_angle_assist_mapper: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/jaam_pkg.sv
rtl/jaam_cfg.sv
rtl/jaam_cordic.sv
rtl/joint_angle_assist_mapper.sv
tb/tb.sv
